// ===== hdl/dpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types, widths and codes for the debounced passage countdown.
// ----------------------------------------------------------------------------
package dpc_pkg;

  // Width of the passage counter
  localparam int CNT_W = 16;

  // Field widths
  localparam int TS_W   = 32;
  localparam int REM_W  = 16;
  localparam int DEB_W  = 16;
  localparam int INIT_W = 16;
  localparam int EV_W   = 2;

  // Configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-1:0] REG_INIT_COUNT    = 2'd0;
  localparam logic [CFG_AW-1:0] REG_DEBOUNCE_TIME = 2'd1;
  localparam logic [CFG_AW-1:0] REG_PRES_LIMIT    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [INIT_W-1:0] INIT_COUNT_RST = 16'd0;
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 16'd50;
  localparam logic [TS_W-1:0]   PRES_LIMIT_RST = 32'd5000;

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_START  = 1'b1;

  // Event codes
  localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EV_W-1:0] EV_MOTION  = 2'd1;
  localparam logic [EV_W-1:0] EV_PASSAGE = 2'd2;
  localparam logic [EV_W-1:0] EV_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [INIT_W-1:0] initial_count;
    logic [DEB_W-1:0]  debounce_time;
    logic [TS_W-1:0]   presence_limit;
  } cfg_t;

  typedef struct packed {
    logic            op;
    logic [TS_W-1:0] now_ms;
    logic            pir_level;
  } item_t;

  typedef struct packed {
    logic [REM_W-1:0] remaining;
    logic             gate_open;
    logic             running;
    logic [EV_W-1:0]  event_res;
    logic             finished;
  } result_t;

  typedef struct packed {
    logic             active;
    logic             stable_level;
    logic             presence_seen;
    logic [CNT_W-1:0] count_left;
    logic [TS_W-1:0]  last_change_time;
    logic [TS_W-1:0]  presence_start_time;
    logic             gate_state;
  } state_t;

endpackage

// ===== hdl/dpc_ifs.sv =====
// ----------------------------------------------------------------------------
// dpc_ifs
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface dpc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] now_ms;
  logic        pir_level;

  modport source (output valid, output op, output now_ms, output pir_level, input ready);
  modport sink   (input valid, input op, input now_ms, input pir_level, output ready);
endinterface

interface dpc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] remaining;
  logic        gate_open;
  logic        running;
  logic [1:0]  event_res;
  logic        finished;

  modport source (output valid, output remaining, output gate_open, output running,
                  output event_res, output finished, input ready);
  modport sink   (input valid, input remaining, input gate_open, input running,
                  input event_res, input finished, output ready);
endinterface

// ===== hdl/dpc_cfg.sv =====
// ----------------------------------------------------------------------------
// dpc_cfg
// Configuration register bank written through a plain write port.
// ----------------------------------------------------------------------------
module dpc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dpc_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [dpc_pkg::CFG_DW-1:0]   cfg_wdata,
  output dpc_pkg::cfg_t                cfg
);
  import dpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write index
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_INIT_COUNT:    cfg_nxt.initial_count  = cfg_wdata[INIT_W-1:0];
        REG_DEBOUNCE_TIME: cfg_nxt.debounce_time  = cfg_wdata[DEB_W-1:0];
        REG_PRES_LIMIT:    cfg_nxt.presence_limit = cfg_wdata[TS_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_count  <= INIT_COUNT_RST;
      cfg_r.debounce_time  <= DEBOUNCE_RST;
      cfg_r.presence_limit <= PRES_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/dpc_engine.sv =====
// ----------------------------------------------------------------------------
// dpc_engine
// Debounce, presence tracking and passage countdown for one item per cycle while step_en is high.
// ----------------------------------------------------------------------------
module dpc_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  dpc_pkg::item_t    item,
  input  dpc_pkg::cfg_t     cfg,
  output dpc_pkg::result_t  res
);
  import dpc_pkg::*;

  state_t           st_r;
  state_t           st_nxt;
  logic [TS_W-1:0]  chg_diff;
  logic [TS_W-1:0]  pres_diff;
  logic             take;
  logic [EV_W-1:0]  ev;
  logic             fin;
  logic [31:0]      cnt_wide;

  // Compute next state and result for the current item
  always_comb begin
    st_nxt    = st_r;
    ev        = EV_NONE;
    fin       = 1'b0;
    take      = 1'b0;
    chg_diff  = item.now_ms - st_r.last_change_time;
    pres_diff = '0;
    if (item.op == OP_START) begin
      st_nxt.count_left = CNT_W'(cfg.initial_count);
      st_nxt.active     = 1'b1;
    end else if (st_r.active) begin
      // Accept a debounced level change
      if ((item.pir_level != st_r.stable_level) &&
          (chg_diff >= TS_W'(cfg.debounce_time))) begin
        st_nxt.last_change_time = item.now_ms;
        st_nxt.stable_level     = item.pir_level;
        if (item.pir_level) begin
          st_nxt.presence_seen       = 1'b1;
          st_nxt.presence_start_time = item.now_ms;
          ev                         = EV_MOTION;
        end else if (st_r.presence_seen) begin
          st_nxt.presence_seen = 1'b0;
          ev                   = EV_PASSAGE;
          take                 = 1'b1;
        end
      end
      // Timeout on held presence; only reachable when no passage was taken
      pres_diff = item.now_ms - st_nxt.presence_start_time;
      if (st_nxt.presence_seen && (pres_diff >= cfg.presence_limit)) begin
        st_nxt.presence_seen = 1'b0;
        st_nxt.stable_level  = 1'b0;
        ev                   = EV_TIMEOUT;
        take                 = 1'b1;
      end
      // Decrement without wrap, stop at zero
      if (take) begin
        if (st_r.count_left != '0) begin
          st_nxt.count_left = st_r.count_left - CNT_W'(1);
        end
        if (st_nxt.count_left == '0) begin
          st_nxt.active = 1'b0;
          fin           = 1'b1;
        end
      end
      st_nxt.gate_state = (st_nxt.count_left != '0);
    end
  end

  // Widen the counter before taking the reported bits
  assign cnt_wide = 32'(st_nxt.count_left);

  always_comb begin
    res.remaining = cnt_wide[REM_W-1:0];
    res.gate_open = st_nxt.gate_state;
    res.running   = st_nxt.active;
    res.event_res = ev;
    res.finished  = fin;
  end

  // Hold state, advance on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== hdl/debounced_passage_countdown.sv =====
// ----------------------------------------------------------------------------
// debounced_passage_countdown
// Motion-sensor passage counter with debounce, presence timeout and gate.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : valid/ready channel of items (op, now_ms, pir_level). op selects
//            a start command or a timestamped sensor sample.
//   out_if : valid/ready channel with one result per item (remaining,
//            gate_open, running, event_res, finished), in item order.
//   cfg_*  : write port for initial_count, debounce_time, presence_limit;
//            write only while no transaction is in flight.
//   Path: each item passes the input register, then the result register,
//   before its result is valid on out_if.
//   Throughput: one item per cycle while out_if.ready stays high, set by the
//   single state update in the engine.
//   Reset (rst_n low, synchronous) clears counting state and in-flight items
//   and loads the register defaults (0, 50, 5000).
//   When the receiver stalls, the result register holds; the input register
//   can still take a transaction while it is empty, then in_if.ready drops.
// ----------------------------------------------------------------------------
module debounced_passage_countdown (
  input  logic                       clk,
  input  logic                       rst_n,
  dpc_in_if.sink                     in_if,
  dpc_out_if.source                  out_if,
  input  logic                       cfg_we,
  input  logic [dpc_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [dpc_pkg::CFG_DW-1:0] cfg_wdata
);
  import dpc_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    in_vld_r;
  logic    out_vld_r;
  result_t res;
  result_t res_r;
  logic    adv;
  logic    step_en;

  dpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Result register frees up when empty or being taken
  assign adv     = !out_vld_r || out_if.ready;
  assign step_en = adv && in_vld_r;
  assign in_if.ready = !in_vld_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      item_r.op        <= in_if.op;
      item_r.now_ms    <= in_if.now_ms;
      item_r.pir_level <= in_if.pir_level;
    end
  end

  dpc_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_if.valid     = out_vld_r;
  assign out_if.remaining = res_r.remaining;
  assign out_if.gate_open = res_r.gate_open;
  assign out_if.running   = res_r.running;
  assign out_if.event_res = res_r.event_res;
  assign out_if.finished  = res_r.finished;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the debounced passage countdown. A directed table
// covers stopped samples, zero-count start, debounce limits, wrap of the
// timestamp and timeouts; random sensor streams follow under three settings
// per idling phase. Every result is compared field by field against a typed
// result or an in-bench predictor of the counter, gate and event logic.
// ----------------------------------------------------------------------------
module testbench;
  import dpc_pkg::*;

  // One row of the directed table: either a register setting or an item,
  // with an optional hand-written expected result.
  typedef struct packed {
    logic    is_cfg;
    cfg_t    cfg;
    item_t   it;
    logic    typed;
    result_t res;
  } row_t;

  localparam cfg_t    NO_CFG = '0;
  localparam result_t NO_RES = '0;
  localparam int      N_ROWS = 24;

  localparam row_t DIRECTED [N_ROWS] = '{
    // samples while stopped are ignored
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'h1234_5678, 1'b1}, 1'b1, NO_RES},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'hFFFF_FFFF, 1'b0}, 1'b1, NO_RES},
    // start with zero count at reset settings
    '{1'b0, NO_CFG, '{OP_START, 32'h0000_0000, 1'b0}, 1'b1,
      '{16'd0, 1'b0, 1'b1, EV_NONE, 1'b0}},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'd100, 1'b1}, 1'b1,
      '{16'd0, 1'b0, 1'b1, EV_MOTION, 1'b0}},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'd120, 1'b0}, 1'b0, NO_RES},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'd200, 1'b0}, 1'b1,
      '{16'd0, 1'b0, 1'b0, EV_PASSAGE, 1'b1}},
    // all registers at their maximum
    '{1'b1, '{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, '0, 1'b0, NO_RES},
    '{1'b0, NO_CFG, '{OP_START, 32'd0, 1'b1}, 1'b1,
      '{16'hFFFF, 1'b0, 1'b1, EV_NONE, 1'b0}},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'd65735, 1'b1}, 1'b1,
      '{16'hFFFF, 1'b1, 1'b1, EV_MOTION, 1'b0}},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'd131269, 1'b0}, 1'b0, NO_RES},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'd131270, 1'b0}, 1'b0, NO_RES},
    // zero debounce and zero limit: motion and timeout in one item
    '{1'b1, '{16'd2, 16'd0, 32'd0}, '0, 1'b0, NO_RES},
    '{1'b0, NO_CFG, '{OP_START, 32'd7, 1'b0}, 1'b0, NO_RES},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'hFFFF_FFF0, 1'b1}, 1'b0, NO_RES},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'h0000_0005, 1'b1}, 1'b1,
      '{16'd0, 1'b0, 1'b0, EV_TIMEOUT, 1'b1}},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'h0000_0000, 1'b0}, 1'b1, NO_RES},
    // held presence times out, restart in the middle of a run
    '{1'b1, '{16'd5, 16'd10, 32'd100}, '0, 1'b0, NO_RES},
    '{1'b0, NO_CFG, '{OP_START, 32'd900, 1'b0}, 1'b0, NO_RES},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'd1000, 1'b1}, 1'b0, NO_RES},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'd1005, 1'b0}, 1'b0, NO_RES},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'd1050, 1'b1}, 1'b0, NO_RES},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'd1100, 1'b1}, 1'b0, NO_RES},
    '{1'b0, NO_CFG, '{OP_SAMPLE, 32'd1200, 1'b0}, 1'b0, NO_RES},
    '{1'b0, NO_CFG, '{OP_START, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_RES}
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  dpc_in_if  in_ch ();
  dpc_out_if out_ch ();

  debounced_passage_countdown uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the block's settings and counting state
  cfg_t        model_cfg;
  state_t      model_st;
  logic [31:0] sensor_ms;

  result_t     awaited_reports [$];
  int unsigned mismatch_count;
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned hold_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] %s", $time, msg);
    mismatch_count++;
  endtask

  // Count one passage without wrapping below zero; flag a stop
  function automatic logic count_passage();
    if (model_st.count_left != '0) model_st.count_left = model_st.count_left - CNT_W'(1);
    if (model_st.count_left == '0) begin
      model_st.active = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the mirrored state by one item and return its result
  function automatic result_t predict_passage(item_t it);
    result_t         r;
    logic [EV_W-1:0] ev;
    logic            fin;
    logic [TS_W-1:0] since_change;
    logic [TS_W-1:0] since_presence;
    ev  = EV_NONE;
    fin = 1'b0;
    if (it.op == OP_START) begin
      model_st.count_left = model_cfg.initial_count;
      model_st.active     = 1'b1;
    end else if (model_st.active) begin
      since_change = it.now_ms - model_st.last_change_time;
      if (it.pir_level != model_st.stable_level &&
          since_change >= TS_W'(model_cfg.debounce_time)) begin
        model_st.last_change_time = it.now_ms;
        model_st.stable_level     = it.pir_level;
        if (it.pir_level) begin
          model_st.presence_seen       = 1'b1;
          model_st.presence_start_time = it.now_ms;
          ev = EV_MOTION;
        end else if (model_st.presence_seen) begin
          model_st.presence_seen = 1'b0;
          ev = EV_PASSAGE;
          if (count_passage()) fin = 1'b1;
        end
      end
      // timeout overrides any edge seen in the same item
      since_presence = it.now_ms - model_st.presence_start_time;
      if (model_st.active && model_st.presence_seen &&
          since_presence >= model_cfg.presence_limit) begin
        model_st.presence_seen = 1'b0;
        model_st.stable_level  = 1'b0;
        ev = EV_TIMEOUT;
        if (count_passage()) fin = 1'b1;
      end
      model_st.gate_state = (model_st.count_left != '0);
    end
    r.remaining = model_st.count_left;
    r.gate_open = model_st.gate_state;
    r.running   = model_st.active;
    r.event_res = ev;
    r.finished  = fin;
    return r;
  endfunction

  // Mostly well-formed sensor streams around the debounce and limit times
  function automatic item_t next_random_item();
    item_t       it;
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(99);
    it.op        = OP_SAMPLE;
    it.now_ms    = sensor_ms;
    it.pir_level = 1'($urandom_range(1));
    if (!model_st.active ? (roll < 85) : (roll < 3)) begin
      it.op     = OP_START;
      it.now_ms = $urandom();
    end else if (roll >= 95) begin
      it.now_ms = $urandom();
    end else begin
      span = (model_cfg.presence_limit > 2000) ? 2000 : model_cfg.presence_limit;
      case ($urandom_range(9))
        0, 1, 2: sensor_ms = sensor_ms +
                             $urandom_range(32'(model_cfg.debounce_time) + 32'd5);
        9:       sensor_ms = sensor_ms + $urandom();
        default: sensor_ms = sensor_ms + 32'(model_cfg.debounce_time) +
                             $urandom_range(span);
      endcase
      it.now_ms = sensor_ms;
      if ($urandom_range(9) < 7) it.pir_level = ~model_st.stable_level;
    end
    return it;
  endfunction

  function automatic cfg_t pick_setting(int unsigned kind);
    cfg_t c;
    case (kind)
      0: begin
        c.initial_count  = INIT_W'($urandom_range(1, 12));
        c.debounce_time  = DEB_W'($urandom_range(0, 120));
        c.presence_limit = $urandom_range(20, 900);
      end
      1: begin
        c.initial_count  = '1;
        c.debounce_time  = '1;
        c.presence_limit = '1;
      end
      default: begin
        c.initial_count  = '0;
        c.debounce_time  = '0;
        c.presence_limit = $urandom_range(0, 3);
      end
    endcase
    return c;
  endfunction

  // Offer one item, hold it until taken, then log its expected result
  task automatic send_item(item_t it, logic typed, result_t typed_res);
    result_t predicted;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= it.op;
    in_ch.now_ms    <= it.now_ms;
    in_ch.pir_level <= it.pir_level;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = predict_passage(it);
    awaited_reports.push_back(typed ? typed_res : predicted);
  endtask

  // Drop valid and wait for every awaited result, then let the pipe settle
  task automatic wait_quiet();
    int unsigned guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (awaited_reports.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (awaited_reports.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_reports.size()));
    awaited_reports.delete();
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges
  task automatic apply_config(cfg_t c);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_INIT_COUNT;
    cfg_wdata <= CFG_DW'(c.initial_count);
    @(posedge clk);
    cfg_addr  <= REG_DEBOUNCE_TIME;
    cfg_wdata <= CFG_DW'(c.debounce_time);
    @(posedge clk);
    cfg_addr  <= REG_PRES_LIMIT;
    cfg_wdata <= CFG_DW'(c.presence_limit);
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_cfg = c;
  endtask

  task automatic check_result(result_t got, result_t want);
    if (got.remaining !== want.remaining)
      report_mismatch($sformatf("remaining got %0d want %0d", got.remaining, want.remaining));
    if (got.gate_open !== want.gate_open)
      report_mismatch($sformatf("gate_open got %0b want %0b", got.gate_open, want.gate_open));
    if (got.running !== want.running)
      report_mismatch($sformatf("running got %0b want %0b", got.running, want.running));
    if (got.event_res !== want.event_res)
      report_mismatch($sformatf("event_res got %0d want %0d", got.event_res, want.event_res));
    if (got.finished !== want.finished)
      report_mismatch($sformatf("finished got %0b want %0b", got.finished, want.finished));
  endtask

  // Drive result ready: long hold-off when requested, else random stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.remaining = out_ch.remaining;
      got.gate_open = out_ch.gate_open;
      got.running   = out_ch.running;
      got.event_res = out_ch.event_res;
      got.finished  = out_ch.finished;
      if (awaited_reports.size() == 0)
        report_mismatch("result transaction with no expectation");
      else
        check_result(got, awaited_reports.pop_front());
    end
  end

  initial begin
    int i;
    int phase;
    int seg;
    mismatch_count = 0;
    hold_left      = 0;
    send_idle      = 14;
    recv_idle      = 70;
    sensor_ms      = '0;
    model_st       = '0;
    model_cfg      = '{INIT_COUNT_RST, DEBOUNCE_RST, PRES_LIMIT_RST};
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_addr        <= REG_INIT_COUNT;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_SAMPLE;
    in_ch.now_ms    <= '0;
    in_ch.pir_level <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (i = 0; i < N_ROWS; i++) begin
      if (DIRECTED[i].is_cfg) begin
        wait_quiet();
        apply_config(DIRECTED[i].cfg);
      end else begin
        send_item(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].res);
      end
    end

    // Random streams: slow receiver, then slow sender, then no idling
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 14; recv_idle = 70; end
        1: begin send_idle = 70; recv_idle = 14; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (seg = 0; seg < 3; seg++) begin
        wait_quiet();
        apply_config(pick_setting(seg));
        // stall the receiver long enough to back up the input
        if (phase == 2 && seg == 0) hold_left = 250;
        repeat (60) send_item(next_random_item(), 1'b0, NO_RES);
      end
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
